// File: hw/rtl/ansi_text_console_writer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ANSI text console writer
// Shared concurrent check forms; each use sits on a line of its own.
// ---------------------------------------------------------------------------
`ifndef ANSI_TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define ANSI_TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define ANSIW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ANSIW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/ansiw_pkg.sv
// ---------------------------------------------------------------------------
// ansiw_pkg
// Shared types, character codes and SGR attribute helpers.
// ---------------------------------------------------------------------------
package ansiw_pkg;

	localparam int unsigned MAX_PARAMS_DEF = 8;
	localparam int unsigned FIFO_DEPTH_DEF = 4;
	localparam int unsigned TAB_STOP       = 4;
	localparam int unsigned TAB_BITS       = $clog2(TAB_STOP);
	localparam int unsigned MAX_RES        = 12;

	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_LBRACK  = 8'h5b;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_M       = 8'h6d;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] ATTR_RESET = 8'h07;

	localparam logic [1:0] CFG_COLUMNS   = 2'd0;
	localparam logic [1:0] CFG_ROWS      = 2'd1;
	localparam logic [1:0] CFG_TEXT_MODE = 2'd2;

	typedef enum logic [1:0] {
		KIND_CELL   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic [7:0] attr;
		logic       last_of_byte;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] cell_index;
		logic [7:0]  glyph;
		logic [7:0]  attribute;
		logic [7:0]  cursor_col;
		logic [7:0]  cursor_row;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0] columns;
		logic [7:0] rows;
		logic       text_mode_on;
	} cfg_t;

	function automatic logic [2:0] color_map(input logic [2:0] c);
		logic [2:0] r;
		case (c)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [7:0] p);
		logic [7:0] off30;
		logic [7:0] off40;
		logic [7:0] r;
		off30 = p - 8'd30;
		off40 = p - 8'd40;
		if (p == 8'd0)
			r = ATTR_RESET;
		else if (p >= 8'd30 && p <= 8'd37)
			r = {attr[7:3], color_map(off30[2:0])};
		else if (p >= 8'd40 && p <= 8'd47)
			r = {attr[7], color_map(off40[2:0]), attr[3:0]};
		else if (p == 8'd5)
			r = attr | 8'h80;
		else if (p == 8'd25)
			r = attr & 8'h7f;
		else
			r = attr;
		return r;
	endfunction

endpackage

// File: hw/rtl/ansi_text_console_writer_top.sv
// ---------------------------------------------------------------------------
// ansi_text_console_writer_top
// Byte-stream text console with ANSI SGR attribute handling.
// ---------------------------------------------------------------------------
// The parser takes one byte per cycle while the print queue has room; an
// 'm' ending an SGR sequence then applies each stored parameter to the
// attribute in order, and an ESC followed by anything but '[' queues both
// bytes; no byte is taken meanwhile. The cursor engine drains the queue
// one entry at a time: take, cell write, advance, cursor update and end
// marker for an ordinary byte, with a scroll when it wraps past the last
// row; a line feed or carriage return skips the cell write and advance, a
// backspace skips the advance, and a tab repeats cell write and advance up
// to the next tab stop, so this engine sets throughput. Results leave via an
// output register after a one-slot hold, so each byte's last is flagged.
module ansi_text_console_writer_top #(
	parameter int unsigned MAX_PARAMS = ansiw_pkg::MAX_PARAMS_DEF,
	parameter int unsigned FIFO_DEPTH = ansiw_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] cell_index,
	output logic [7:0]  glyph,
	output logic [7:0]  attribute,
	output logic [7:0]  cursor_col,
	output logic [7:0]  cursor_row,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	ansiw_pkg::cfg_t cfg_q;
	ansiw_pkg::entry_t push_data, pop_data;
	ansiw_pkg::result_t out_res;
	logic push, pop, full, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{columns: 8'd80, rows: 8'd25, text_mode_on: 1'b1};
		end else if (cfg_valid) begin
			case (cfg_index)
				ansiw_pkg::CFG_COLUMNS:   cfg_q.columns <= cfg_data;
				ansiw_pkg::CFG_ROWS:      cfg_q.rows <= cfg_data;
				ansiw_pkg::CFG_TEXT_MODE: cfg_q.text_mode_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ansiw_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.char_in   (char_in),
		.in_ready  (in_ready),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ansiw_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	ansiw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind       = out_res.kind;
	assign cell_index = out_res.cell_index;
	assign glyph      = out_res.glyph;
	assign attribute  = out_res.attribute;
	assign cursor_col = out_res.cursor_col;
	assign cursor_row = out_res.cursor_row;
	assign last       = out_res.last;
endmodule

// File: hw/rtl/ansiw_fifo.sv
// ---------------------------------------------------------------------------
// ansiw_fifo
// Short queue of print entries between the parser and the cursor engine.
// ---------------------------------------------------------------------------
module ansiw_fifo #(
	parameter int unsigned DEPTH = ansiw_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ansiw_pkg::entry_t push_data,
	output logic              full,
	input  logic              pop,
	output ansiw_pkg::entry_t pop_data,
	output logic              empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ansiw_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

// File: hw/rtl/ansiw_front.sv
// ---------------------------------------------------------------------------
// ansiw_front
// Escape parser: tracks ESC / CSI state, collects SGR parameters, applies
// them to the attribute and queues text and control bytes tagged with it.
// ---------------------------------------------------------------------------
module ansiw_front #(
	parameter int unsigned MAX_PARAMS = ansiw_pkg::MAX_PARAMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        char_in,
	output logic              in_ready,
	output logic              push,
	output ansiw_pkg::entry_t push_data,
	input  logic              full
);
	localparam int unsigned TW = $clog2(MAX_PARAMS + 1);
	localparam int unsigned IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	typedef enum logic [4:0] {
		F_TEXT  = 5'b00001,
		F_ESC   = 5'b00010,
		F_CSI   = 5'b00100,
		F_APPLY = 5'b01000,
		F_PAIR  = 5'b10000
	} fstate_t;

	fstate_t state_q;
	logic [7:0] attr_q, accum_q, pair_q;
	logic [TW-1:0] total_q, idx_q;
	logic [7:0] store_q [MAX_PARAMS];
	logic accept, is_digit, store_param;
	logic [7:0] digit, accum_next;

	assign in_ready = (state_q == F_TEXT || state_q == F_ESC || state_q == F_CSI) && !full;
	assign accept   = in_valid && in_ready;
	assign is_digit = (char_in >= ansiw_pkg::CH_ZERO) && (char_in <= ansiw_pkg::CH_NINE);
	assign digit    = char_in - ansiw_pkg::CH_ZERO;
	assign accum_next = {accum_q[4:0], 3'b000} + {accum_q[6:0], 1'b0} + digit;
	assign store_param = accept && state_q == F_CSI
		&& (char_in == ansiw_pkg::CH_SEMI || char_in == ansiw_pkg::CH_M)
		&& total_q < TW'(MAX_PARAMS);

	always_comb begin
		push      = 1'b0;
		push_data = '{glyph: char_in, attr: attr_q, last_of_byte: 1'b1};
		unique case (state_q)
			F_TEXT: push = accept && char_in != ansiw_pkg::CH_ESC;
			F_ESC: begin
				push = accept && char_in != ansiw_pkg::CH_LBRACK;
				push_data.glyph = ansiw_pkg::CH_ESC;
				push_data.last_of_byte = 1'b0;
			end
			F_PAIR: begin
				push = !full;
				push_data.glyph = pair_q;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_param)
			store_q[total_q[IW-1:0]] <= accum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_TEXT;
			attr_q  <= ansiw_pkg::ATTR_RESET;
			accum_q <= '0;
			pair_q  <= '0;
			total_q <= '0;
			idx_q   <= '0;
		end else begin
			if (store_param)
				total_q <= total_q + 1'b1;
			unique case (state_q)
				F_TEXT: begin
					if (accept && char_in == ansiw_pkg::CH_ESC)
						state_q <= F_ESC;
				end
				F_ESC: begin
					if (accept) begin
						if (char_in == ansiw_pkg::CH_LBRACK) begin
							state_q <= F_CSI;
							total_q <= '0;
							accum_q <= '0;
						end else begin
							pair_q  <= char_in;
							state_q <= F_PAIR;
						end
					end
				end
				F_CSI: begin
					if (accept) begin
						if (is_digit) begin
							accum_q <= accum_next;
						end else if (char_in == ansiw_pkg::CH_SEMI) begin
							accum_q <= '0;
						end else if (char_in == ansiw_pkg::CH_M) begin
							idx_q   <= '0;
							state_q <= F_APPLY;
						end else begin
							state_q <= F_TEXT;
						end
					end
				end
				F_APPLY: begin
					// one parameter per cycle, in order
					if (idx_q < total_q) begin
						attr_q <= ansiw_pkg::sgr_apply(attr_q, store_q[idx_q[IW-1:0]]);
						idx_q  <= idx_q + 1'b1;
					end else begin
						state_q <= F_TEXT;
					end
				end
				F_PAIR: begin
					if (!full)
						state_q <= F_TEXT;
				end
				default: state_q <= F_TEXT;
			endcase
		end
	end
endmodule

// File: hw/rtl/ansiw_back.sv
// ---------------------------------------------------------------------------
// ansiw_back
// Cursor engine: carries out queued print entries, emits cell writes,
// scrolls and cursor updates, and marks the last result of each byte.
// ---------------------------------------------------------------------------
`include "ansi_text_console_writer_top_assert.svh"

module ansiw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ansiw_pkg::cfg_t    cfg,
	input  logic               empty,
	output logic               pop,
	input  ansiw_pkg::entry_t  pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ansiw_pkg::result_t out_res
);
	typedef enum logic [5:0] {
		B_IDLE   = 6'b000001,
		B_CELL   = 6'b000010,
		B_ADV    = 6'b000100,
		B_SCROLL = 6'b001000,
		B_CURSOR = 6'b010000,
		B_FLUSH  = 6'b100000
	} bstate_t;

	bstate_t state_q;
	logic [7:0] col_q, row_q, cglyph_q, attr_q;
	logic adv_q, tab_q, end_q;
	ansiw_pkg::result_t pend_q, out_q, res, pend_last;
	logic pend_v_q, out_v_q;
	logic [3:0] cnt_q;
	logic emit, can_push, stall, take, flush_out, load_out;
	logic [15:0] prod;
	logic [7:0] col_inc, row_inc;

	assign prod     = {8'b0, row_q} * {8'b0, cfg.columns};
	assign col_inc  = col_q + 8'd1;
	assign row_inc  = row_q + 8'd1;
	assign can_push = !out_v_q || out_ready;
	assign flush_out = (state_q == B_FLUSH) && pend_v_q;
	assign stall    = (emit || flush_out) && !can_push;
	assign take     = emit && !stall && cnt_q < 4'(ansiw_pkg::MAX_RES);
	assign load_out = (take || (state_q == B_FLUSH && !stall)) && pend_v_q;
	assign pop      = (state_q == B_IDLE) && !empty;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	always_comb begin
		emit = 1'b0;
		res  = '{kind: ansiw_pkg::KIND_CELL, cell_index: 16'd0, glyph: 8'd0,
			attribute: 8'd0, cursor_col: 8'd0, cursor_row: 8'd0, last: 1'b0};
		unique case (state_q)
			B_CELL: begin
				emit = 1'b1;
				res.cell_index = prod + {8'b0, col_q};
				res.glyph      = cglyph_q;
				res.attribute  = attr_q;
			end
			B_SCROLL: begin
				emit = 1'b1;
				res.kind      = ansiw_pkg::KIND_SCROLL;
				res.glyph     = ansiw_pkg::CH_SPACE;
				res.attribute = attr_q;
			end
			B_CURSOR: begin
				emit = cfg.text_mode_on;
				res.kind       = ansiw_pkg::KIND_CURSOR;
				res.cursor_col = col_q;
				res.cursor_row = row_q;
			end
			default: emit = 1'b0;
		endcase
	end

	// output register and one-deep hold of the newest result
	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= res;
			if (pend_v_q)
				out_q <= pend_q;
		end else if (flush_out && !stall) begin
			out_q <= pend_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (load_out)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
			if (take) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + 4'd1;
			end else if (state_q == B_FLUSH && !stall) begin
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			cglyph_q <= '0;
			attr_q   <= '0;
			adv_q    <= 1'b0;
			tab_q    <= 1'b0;
			end_q    <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						cglyph_q <= pop_data.glyph;
						attr_q   <= pop_data.attr;
						end_q    <= pop_data.last_of_byte;
						adv_q    <= 1'b1;
						tab_q    <= 1'b0;
						unique case (pop_data.glyph)
							ansiw_pkg::CH_NL: begin
								col_q   <= '0;
								row_q   <= row_inc;
								state_q <= (row_inc >= cfg.rows) ? B_SCROLL : B_CURSOR;
							end
							ansiw_pkg::CH_CR: begin
								col_q   <= '0;
								state_q <= B_CURSOR;
							end
							ansiw_pkg::CH_BS: begin
								if (col_q != 8'd0) begin
									col_q <= col_q - 8'd1;
								end else if (row_q != 8'd0) begin
									row_q <= row_q - 8'd1;
									col_q <= cfg.columns - 8'd1;
								end
								cglyph_q <= ansiw_pkg::CH_SPACE;
								adv_q    <= 1'b0;
								state_q  <= B_CELL;
							end
							ansiw_pkg::CH_TAB: begin
								cglyph_q <= ansiw_pkg::CH_SPACE;
								tab_q    <= 1'b1;
								state_q  <= B_CELL;
							end
							default: state_q <= B_CELL;
						endcase
					end
				end
				B_CELL: begin
					if (!stall)
						state_q <= adv_q ? B_ADV : B_CURSOR;
				end
				B_ADV: begin
					if (col_inc >= cfg.columns) begin
						col_q   <= '0;
						row_q   <= row_inc;
						state_q <= (row_inc >= cfg.rows) ? B_SCROLL : B_CURSOR;
					end else begin
						col_q <= col_inc;
						// keep blanking until the next tab stop
						state_q <= (tab_q && col_inc[ansiw_pkg::TAB_BITS-1:0] != '0)
							? B_CELL : B_CURSOR;
					end
				end
				B_SCROLL: begin
					if (!stall) begin
						if (row_q != 8'd0)
							row_q <= row_q - 8'd1;
						state_q <= B_CURSOR;
					end
				end
				B_CURSOR: begin
					if (!stall)
						state_q <= end_q ? B_FLUSH : B_IDLE;
				end
				B_FLUSH: begin
					if (!stall)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`ANSIW_ASSERT(a_cnt_cap, cnt_q <= 4'(ansiw_pkg::MAX_RES), "result count above cap")
	`ANSIW_ASSERT(a_pend_cnt, (cnt_q == 4'd0) == !pend_v_q, "held result and count disagree")
	`ANSIW_ASSERT(a_flush_clr, (state_q == B_FLUSH && !stall) |=> (!pend_v_q && cnt_q == 4'd0), "flush left a held result")
	`ANSIW_NEVER(a_pop_busy, pop && state_q != B_IDLE, "entry taken while engine busy")
endmodule
